// ===== design/lcs_pkg.sv =====
// Shared constants and types for the largest checkerboard square block.
// No dependencies; used by lcs_front, lcs_back and the top module.
`default_nettype none
package lcs_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam int SIDE_W       = 7;
  localparam int POS_W        = 6;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int LB_W         = SIDE_W + 1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd5;
  localparam logic [SIDE_W-1:0] SIDE_ONE   = 7'd1;
  localparam logic [SIDE_W-1:0] SIDE_SAT   = 7'd127;

  typedef struct packed {
    logic cur;
    logic last;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

endpackage
`default_nettype wire

// ===== design/lcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/lcs_queue.sv =====
// Two-entry queue between the front and back parts.
// No package dependency.
`default_nettype none
module lcs_queue #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head,
  output logic                  empty
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/lcs_front.sv =====
// Front part: accepts cell beats, holds the side register and the raster
// position counters, and tags each beat with its row, column and end flag.
// Depends on lcs_pkg.
`default_nettype none
module lcs_front #(
  parameter int MAX_SIDE = lcs_pkg::MAX_SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lcs_pkg::SIDE_W-1:0]    cfg_wr_data,
  input  wire logic                          accept,
  input  wire logic                          cell_bit,
  input  wire logic                          first,
  output logic [lcs_pkg::FLAGS_W+2*$clog2(MAX_SIDE)-1:0] entry
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int EW = (CW + 1 > lcs_pkg::SIDE_W) ? CW + 1 : lcs_pkg::SIDE_W;

  logic [lcs_pkg::SIDE_W-1:0] side_r;
  logic [CW-1:0]              row_r, col_r, row_nxt, col_nxt;
  logic [CW-1:0]              r, c;
  logic [EW-1:0]              side_e, n, c_inc, r_inc;
  logic                       last_col, last;
  lcs_pkg::flags_t            flags;

  always_comb begin
    side_e = EW'(side_r);
    n = side_e;
    if (side_r == '0) begin
      n = EW'(1);
    end else if (side_e > EW'(MAX_SIDE)) begin
      n = EW'(MAX_SIDE);
    end
    r        = first ? '0 : row_r;
    c        = first ? '0 : col_r;
    c_inc    = EW'(c) + EW'(1);
    r_inc    = EW'(r) + EW'(1);
    last_col = (c_inc >= n);
    last     = last_col && (r_inc >= n);
    row_nxt  = row_r;
    col_nxt  = c + CW'(1);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last ? '0 : r + CW'(1);
    end else begin
      row_nxt = r;
    end
    flags.cur  = cell_bit;
    flags.last = last;
    entry      = {flags, r, c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= lcs_pkg::SIDE_RESET;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        side_r <= cfg_wr_data;
      end
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lcs_back.sv =====
// Back part: reads the line buffer, runs the checkerboard recurrence and
// best tracking, and holds the result beat in the output register.
// Depends on lcs_pkg and lcs_ram.
`default_nettype none
module lcs_back #(
  parameter int MAX_SIDE = lcs_pkg::MAX_SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire logic [lcs_pkg::FLAGS_W+2*$clog2(MAX_SIDE)-1:0] q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lcs_pkg::SIDE_W-1:0]         o_square,
  output logic [lcs_pkg::SIDE_W-1:0]         o_best,
  output logic [lcs_pkg::POS_W-1:0]          o_row,
  output logic [lcs_pkg::POS_W-1:0]          o_col,
  output logic                               o_last
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = lcs_pkg::SIDE_W;

  // work stage
  logic            b_valid_r;
  lcs_pkg::flags_t b_flags_r;
  logic [CW-1:0]   b_r_r, b_c_r;
  logic            fwd_r;
  logic [SW:0]     fwd_data_r;
  // neighbours and best
  logic            left_bit_r, ul_bit_r;
  logic [SW-1:0]   left_side_r, ul_side_r;
  logic [SW-1:0]   best_side_r;
  logic [CW-1:0]   best_r_r, best_c_r;
  logic [SW-1:0]   best_side_nxt;
  logic [CW-1:0]   best_r_nxt, best_c_nxt;
  // output register
  logic            out_valid_r;
  logic [SW-1:0]   o_square_r, o_best_r;
  logic [lcs_pkg::POS_W-1:0] o_row_r, o_col_r;
  logic            o_last_r;

  logic            out_free, b_adv;
  logic [CW-1:0]   q_c;
  logic [SW:0]     ram_rdata, up;
  logic            up_bit;
  logic [SW-1:0]   up_side, m1, mn, res;
  logic [SW:0]     sum;
  logic            corner, edge_cell, chk;
  logic [CW+lcs_pkg::POS_W-1:0] row_ext, col_ext;

  assign out_free = !out_valid_r || out_ready;
  assign b_adv    = b_valid_r && out_free;
  assign q_pop    = !q_empty && (!b_valid_r || b_adv);
  assign q_c      = q_head[CW-1:0];

  lcs_ram #(
    .WIDTH (lcs_pkg::LB_W),
    .DEPTH (MAX_SIDE)
  ) u_line (
    .clk   (clk),
    .we    (b_adv),
    .waddr (b_c_r),
    .wdata ({b_flags_r.cur, res}),
    .re    (q_pop),
    .raddr (q_c),
    .rdata (ram_rdata)
  );

  always_comb begin
    up        = fwd_r ? fwd_data_r : ram_rdata;
    up_bit    = up[SW];
    up_side   = up[SW-1:0];
    m1        = (ul_side_r < up_side) ? ul_side_r : up_side;
    mn        = (m1 < left_side_r) ? m1 : left_side_r;
    sum       = {1'b0, mn} + {{SW{1'b0}}, 1'b1};
    edge_cell = (b_r_r == '0) || (b_c_r == '0);
    corner    = (b_r_r == '0) && (b_c_r == '0);
    chk       = (b_flags_r.cur == ul_bit_r) && (up_bit == left_bit_r) &&
                (b_flags_r.cur != up_bit);
    res       = lcs_pkg::SIDE_ONE;
    if (!edge_cell && chk) begin
      res = sum[SW] ? lcs_pkg::SIDE_SAT : sum[SW-1:0];
    end
    best_side_nxt = best_side_r;
    best_r_nxt    = best_r_r;
    best_c_nxt    = best_c_r;
    if (corner) begin
      best_side_nxt = lcs_pkg::SIDE_ONE;
      best_r_nxt    = '0;
      best_c_nxt    = '0;
    end else if (res > best_side_r) begin
      best_side_nxt = res;
      best_r_nxt    = b_r_r;
      best_c_nxt    = b_c_r;
    end
    row_ext = {{lcs_pkg::POS_W{1'b0}}, best_r_nxt};
    col_ext = {{lcs_pkg::POS_W{1'b0}}, best_c_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      left_bit_r  <= 1'b0;
      left_side_r <= lcs_pkg::SIDE_ONE;
      ul_bit_r    <= 1'b0;
      ul_side_r   <= lcs_pkg::SIDE_ONE;
      best_side_r <= lcs_pkg::SIDE_ONE;
      best_r_r    <= '0;
      best_c_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid_r <= 1'b1;
        fwd_r     <= b_adv && (q_c == b_c_r);
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        ul_bit_r    <= up_bit;
        ul_side_r   <= up_side;
        left_bit_r  <= b_flags_r.cur;
        left_side_r <= res;
        best_side_r <= best_side_nxt;
        best_r_r    <= best_r_nxt;
        best_c_r    <= best_c_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_flags_r  <= lcs_pkg::flags_t'(q_head[2*CW +: lcs_pkg::FLAGS_W]);
      b_r_r      <= q_head[CW +: CW];
      b_c_r      <= q_c;
      fwd_data_r <= {b_flags_r.cur, res};
    end
    if (b_adv) begin
      o_square_r <= res;
      o_best_r   <= best_side_nxt;
      o_row_r    <= row_ext[lcs_pkg::POS_W-1:0];
      o_col_r    <= col_ext[lcs_pkg::POS_W-1:0];
      o_last_r   <= b_flags_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign o_square  = o_square_r;
  assign o_best    = o_best_r;
  assign o_row     = o_row_r;
  assign o_col     = o_col_r;
  assign o_last    = o_last_r;

endmodule
`default_nettype wire

// ===== design/largest_checkerboard_square.sv =====
// Largest checkerboard square: one result beat per input beat, one beat per
// cycle sustained while out_tready stays high. An accepted cell passes
// through the queue, the work stage with its line-buffer read, and the
// output register before its result is valid. Reset clears the position
// counters, the neighbour and best registers and sets side to 5; the line
// buffer is not cleared. Depends on lcs_pkg, lcs_front, lcs_queue, lcs_back, lcs_ram.
`default_nettype none
module largest_checkerboard_square #(
  parameter int MAX_SIDE = lcs_pkg::MAX_SIDE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lcs_pkg::SIDE_W-1:0]     cfg_wr_data,   // side
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lcs_pkg::IN_TDATA_W-1:0] in_tdata,      // [0] cell_req
  input  wire logic                           in_tuser,      // first_of_matrix
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [6:0] square_side, [13:7] best_size, [19:14] best_row, [25:20] best_col
  output logic [lcs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast      // last_cell
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int QW = lcs_pkg::FLAGS_W + 2 * CW;

  logic          accept, q_full, q_empty, q_pop;
  logic [QW-1:0] entry, q_head;
  logic [lcs_pkg::SIDE_W-1:0] o_square, o_best;
  logic [lcs_pkg::POS_W-1:0]  o_row, o_col;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  lcs_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .cell_bit    (in_tdata[0]),
    .first       (in_tuser),
    .entry       (entry)
  );

  lcs_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lcs_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .o_square  (o_square),
    .o_best    (o_best),
    .o_row     (o_row),
    .o_col     (o_col),
    .o_last    (out_tlast)
  );

  assign out_tdata = {6'd0, o_col, o_row, o_best, o_square};

endmodule
`default_nettype wire
